FILE: src/hsl2rgb_pkg.sv
// Shared constants for the HSL to RGB converter: fixed-point formats, ramp knees, stage counts.
`default_nettype none

package hsl2rgb_pkg;

    // Internal fraction bits; levels are Q1.F, turn fractions Q0.F.
    localparam int FRAC_BITS = 16;
    localparam int QW        = FRAC_BITS + 1;
    localparam int TW        = FRAC_BITS;

    localparam int HUE_W  = 15;
    localparam int IN_W   = 17;
    localparam int BYTE_W = 8;

    localparam logic [QW-1:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

    // 360 degrees in 1/64 degree steps
    localparam logic [HUE_W-1:0] HUE_STEPS = 15'd23040;

    // floor((hue << F) / 23040) as (hue * HUE_RECIP) >> HUE_SHIFT.
    // Reciprocal is ceil(2^HUE_K / 23040); exact for dividends below 2^(HUE_K-15).
    localparam int HUE_K     = 46;
    localparam int HUE_SHIFT = HUE_K - FRAC_BITS;
    localparam int RECIP_W   = 32;
    localparam logic [RECIP_W-1:0] HUE_RECIP =
        RECIP_W'(((64'd1 << HUE_K) + 64'd23039) / 64'd23040);

    // 0.333 and 0.666, rounded to nearest
    localparam logic [TW-1:0] C333 = TW'(((longint'(333) << FRAC_BITS) + 500) / 1000);
    localparam logic [TW-1:0] C666 = TW'(((longint'(666) << FRAC_BITS) + 500) / 1000);

    localparam int FRONT_STAGES = 3;
    localparam int RAMP_STAGES  = 4;
    localparam int PIPE_DEPTH   = FRONT_STAGES + RAMP_STAGES;

endpackage

`default_nettype wire

FILE: src/hsl2rgb_ramp.sv
// One color channel: piecewise hue ramp between lo and hi, then scale to a byte.
`default_nettype none

module hsl2rgb_ramp
    import hsl2rgb_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic [TW-1:0]     t,
    input  wire logic [QW-1:0]     hi,
    input  wire logic [QW-1:0]     lo,
    input  wire logic [QW-1:0]     d,
    output logic      [BYTE_W-1:0] level
);

    typedef enum logic [1:0] {SEG_RISE, SEG_HOLD, SEG_FALL, SEG_LOW} seg_t;

    localparam int LW = QW + 2;          // signed level width
    localparam int SW = LW + BYTE_W;     // level * 255

    // ---------------- R1: segment select, multiplier operand
    logic [TW+2:0] t6;
    logic [TW+1:0] t3;
    logic [TW+1:0] diff;
    logic [TW+1:0] dmag;
    logic [TW+4:0] fall6;
    seg_t          seg_next;
    logic [TW-1:0] mag_next;
    logic          neg_next;

    seg_t          seg_reg;
    logic [TW-1:0] mag_reg;
    logic          neg1_reg;
    logic [QW-1:0] hi1_reg;
    logic [QW-1:0] lo1_reg;
    logic [QW-1:0] d1_reg;

    always_comb
    begin
        t6    = {1'b0, t, 2'b00} + {2'b00, t, 1'b0};
        t3    = {2'b00, t} + {1'b0, t, 1'b0};
        diff  = {2'b00, C666} - {2'b00, t};
        dmag  = diff[TW+1] ? ({2'b00, t} - {2'b00, C666}) : diff;
        fall6 = {1'b0, dmag, 2'b00} + {2'b00, dmag, 1'b0};

        if (t6 < {2'b00, ONE_Q})
            seg_next = SEG_RISE;
        else if (!t[TW-1])
            seg_next = SEG_HOLD;
        else if (t3 < {ONE_Q, 1'b0})
            seg_next = SEG_FALL;
        else
            seg_next = SEG_LOW;

        case (seg_next)
            SEG_RISE:
            begin
                mag_next = t6[TW-1:0];
                neg_next = 1'b0;
            end
            SEG_FALL:
            begin
                // falling edge can overshoot past 0.666, giving a negative factor
                mag_next = fall6[TW-1:0];
                neg_next = diff[TW+1];
            end
            default:
            begin
                mag_next = '0;
                neg_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            seg_reg  <= seg_next;
            mag_reg  <= mag_next;
            neg1_reg <= neg_next;
            hi1_reg  <= hi;
            lo1_reg  <= lo;
            d1_reg   <= d;
        end
    end

    // ---------------- R2: (hi - lo) * factor, truncated
    logic [QW+TW-1:0] prod;
    logic [QW-1:0]    p_next;
    logic [QW-1:0]    base_next;

    logic [QW-1:0] p_reg;
    logic [QW-1:0] base_reg;
    logic          neg2_reg;

    always_comb
    begin
        prod      = {{TW{1'b0}}, d1_reg} * {{QW{1'b0}}, mag_reg};
        p_next    = prod[FRAC_BITS +: QW];
        base_next = (seg_reg == SEG_HOLD) ? hi1_reg : lo1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg    <= p_next;
            base_reg <= base_next;
            neg2_reg <= neg1_reg;
        end
    end

    // ---------------- R3: signed level
    logic [LW-1:0] lvl_next;
    logic [LW-1:0] lvl_reg;

    always_comb
    begin
        if (neg2_reg)
            lvl_next = {2'b00, base_reg} - {2'b00, p_reg};
        else
            lvl_next = {2'b00, base_reg} + {2'b00, p_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en)
            lvl_reg <= lvl_next;
    end

    // ---------------- R4: level * 255 >> F, clamp to byte
    logic [SW-1:0]           scaled;
    logic [SW-FRAC_BITS-1:0] v;
    logic [BYTE_W-1:0]       level_next;
    logic [BYTE_W-1:0]       level_reg;

    always_comb
    begin
        scaled = {lvl_reg, {BYTE_W{1'b0}}} - {{BYTE_W{1'b0}}, lvl_reg};
        v      = scaled[FRAC_BITS +: SW-FRAC_BITS];
        if (lvl_reg[LW-1])
            level_next = '0;
        else if (v[SW-FRAC_BITS-1:BYTE_W] != '0)
            level_next = '1;
        else
            level_next = v[BYTE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            level_reg <= level_next;
    end

    assign level = level_reg;

endmodule

`default_nettype wire

FILE: src/hsl_to_rgb_converter.sv
// Top level of the pipelined HSL to RGB pixel converter.
// Each accepted item passes through registers T1, T2, T3 and R1..R4 to red/green/blue.
// Throughput: one item per cycle; the whole pipe advances together and
// freezes only while a result waits on rgb_stall (hsl_stall follows it).
// Reset: rst_n clears the valid bits only; datapath registers need no reset.
`default_nettype none

module hsl_to_rgb_converter
    import hsl2rgb_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,

    input  wire logic              hsl_valid,
    output logic                   hsl_stall,
    input  wire logic [HUE_W-1:0]  hue,
    input  wire logic [IN_W-1:0]   saturation,
    input  wire logic [IN_W-1:0]   lightness,

    output logic                   rgb_valid,
    input  wire logic              rgb_stall,
    output logic      [BYTE_W-1:0] red,
    output logic      [BYTE_W-1:0] green,
    output logic      [BYTE_W-1:0] blue
);

    // Global advance: every stage moves unless the finished result is held.
    logic adv;
    assign adv       = !(rgb_valid && rgb_stall);
    assign hsl_stall = !adv;

    // Valid bits travel alongside the data, one per stage.
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic [PIPE_DEPTH-1:0] vld_next;

    assign vld_next  = {vld_reg[PIPE_DEPTH-2:0], hsl_valid};
    assign rgb_valid = vld_reg[PIPE_DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= vld_next;
    end

    // ---------------- T1: hue wrap into one turn, clamp s and l to 1.0
    // Inputs are already Q1.16, which matches the internal format.
    logic [HUE_W-1:0] hue_next;
    logic [QW-1:0]    s_next;
    logic [QW-1:0]    l_next;

    logic [HUE_W-1:0] hue_reg;
    logic [QW-1:0]    s1_reg;
    logic [QW-1:0]    l1_reg;

    always_comb
    begin
        // Any 15-bit code is below two turns, so one subtract is enough.
        hue_next = (hue >= HUE_STEPS) ? (hue - HUE_STEPS) : hue;
        s_next   = (saturation > ONE_Q) ? ONE_Q : saturation;
        l_next   = (lightness  > ONE_Q) ? ONE_Q : lightness;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hue_reg <= hue_next;
            s1_reg  <= s_next;
            l1_reg  <= l_next;
        end
    end

    // ---------------- T2: hue to turn fraction, l*s product
    // Division by 23040 is a multiply by a reciprocal with exact truncation.
    logic [HUE_W+RECIP_W-1:0] hue_prod;
    logic [2*QW-1:0]          ls_prod;
    logic [TW-1:0]            h_next;
    logic [QW-1:0]            ls_next;
    logic                     lhalf_next;

    logic [TW-1:0] h2_reg;
    logic [QW-1:0] ls2_reg;
    logic [QW-1:0] s2_reg;
    logic [QW-1:0] l2_reg;
    logic          lhalf2_reg;

    always_comb
    begin
        hue_prod   = {{RECIP_W{1'b0}}, hue_reg} * {{HUE_W{1'b0}}, HUE_RECIP};
        h_next     = hue_prod[HUE_SHIFT +: TW];
        ls_prod    = {{QW{1'b0}}, l1_reg} * {{QW{1'b0}}, s1_reg};
        ls_next    = ls_prod[FRAC_BITS +: QW];
        // l < 0.5
        lhalf_next = !l1_reg[FRAC_BITS] && !l1_reg[FRAC_BITS-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h2_reg     <= h_next;
            ls2_reg    <= ls_next;
            s2_reg     <= s1_reg;
            l2_reg     <= l1_reg;
            lhalf2_reg <= lhalf_next;
        end
    end

    // ---------------- T3: hi/lo levels and per-channel hue offsets
    // hi stays within [l, 1.0] and lo within [0, hi] even with truncated l*s,
    // so both fit unsigned Q1.F and d = hi - lo is never negative.
    // Zero saturation needs no path of its own: hi = lo = l gives the grey.
    logic [QW:0]   hi_wide;
    logic [QW:0]   lo_wide;
    logic [QW-1:0] hi_next;
    logic [QW-1:0] lo_next;
    logic [QW-1:0] d_next;

    logic [QW-1:0] hi3_reg;
    logic [QW-1:0] lo3_reg;
    logic [QW-1:0] d3_reg;
    logic [TW-1:0] tr3_reg;
    logic [TW-1:0] tg3_reg;
    logic [TW-1:0] tb3_reg;

    always_comb
    begin
        if (lhalf2_reg)
            hi_wide = {1'b0, l2_reg} + {1'b0, ls2_reg};
        else
            hi_wide = {1'b0, l2_reg} + {1'b0, s2_reg} - {1'b0, ls2_reg};
        lo_wide = {l2_reg, 1'b0} - hi_wide;
        hi_next = hi_wide[QW-1:0];
        lo_next = lo_wide[QW-1:0];
        d_next  = hi_next - lo_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hi3_reg <= hi_next;
            lo3_reg <= lo_next;
            d3_reg  <= d_next;
            // offsets wrap mod one turn through the natural TW-bit overflow
            tr3_reg <= h2_reg + C333;
            tg3_reg <= h2_reg;
            tb3_reg <= h2_reg - C333;
        end
    end

    // ---------------- R1..R4: one ramp per channel, outputs are the result register
    hsl2rgb_ramp u_ramp_red
    (
        .clk   (clk),
        .en    (adv),
        .t     (tr3_reg),
        .hi    (hi3_reg),
        .lo    (lo3_reg),
        .d     (d3_reg),
        .level (red)
    );

    hsl2rgb_ramp u_ramp_green
    (
        .clk   (clk),
        .en    (adv),
        .t     (tg3_reg),
        .hi    (hi3_reg),
        .lo    (lo3_reg),
        .d     (d3_reg),
        .level (green)
    );

    hsl2rgb_ramp u_ramp_blue
    (
        .clk   (clk),
        .en    (adv),
        .t     (tb3_reg),
        .hi    (hi3_reg),
        .lo    (lo3_reg),
        .d     (d3_reg),
        .level (blue)
    );

    // ---------------- checks
    a_front_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] |-> (hue_reg < HUE_STEPS && s1_reg <= ONE_Q && l1_reg <= ONE_Q))
        else $error("T1 hue wrap or clamp out of range");

    a_ls_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[1] |-> (ls2_reg <= l2_reg && h2_reg < {TW{1'b1}}))
        else $error("T2 product or turn fraction out of range");

    a_level_order: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[2] |-> (hi3_reg <= ONE_Q && lo3_reg <= hi3_reg))
        else $error("T3 hi/lo levels out of order");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        hsl_stall |=> $stable(vld_reg))
        else $error("pipeline moved while held");

endmodule

`default_nettype wire
